/* src/maki_pkg.sv */
`default_nettype none
package maki_pkg;

    localparam int MAX_WIDTH    = 640;
    localparam int MAX_HEIGHT   = 400;
    localparam int FLAG_A_BYTES = 1000;
    localparam int FLAG_B_BYTES = 16384;
    localparam int PIXEL_BYTES  = 131072;
    localparam int MAX_GAP_ROWS = 4;

    localparam int VS_NIBBLES   = (MAX_WIDTH / 8) * MAX_HEIGHT;
    localparam int ROW_PAIRS    = MAX_WIDTH / 2;
    localparam int RECENT_DEPTH = MAX_GAP_ROWS * ROW_PAIRS;

    localparam logic [5:0] W16_MAX = 6'(MAX_WIDTH / 16);
    localparam logic [6:0] H4_MAX  = 7'(MAX_HEIGHT / 4);

    localparam logic [2:0] MODE_FLAG_A = 3'd0;
    localparam logic [2:0] MODE_FLAG_B = 3'd1;
    localparam logic [2:0] MODE_PIXEL  = 3'd2;
    localparam logic [2:0] MODE_START  = 3'd3;
    localparam logic [2:0] MODE_FETCH  = 3'd4;

    localparam logic [1:0] REG_WIDTH   = 2'd0;
    localparam logic [1:0] REG_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_VARIANT = 2'd2;

    typedef struct packed {
        logic load;
        logic start;
        logic ex_rd_a;
        logic ex_rd_b;
        logic ex_cap_hi;
        logic ex_cap_lo;
        logic ex_clr;
        logic ex_wr;
        logic fe_rd;
        logic fe_commit;
    } cmd_t;

    typedef struct packed {
        logic frame_active;
        logic fa_bit;
        logic nib_last;
        logic blk_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* src/maki_ctrl.sv */
`default_nettype none
module maki_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_xfer,
    input  wire logic [2:0]        in_mode,
    input  wire maki_pkg::status_t st,
    output logic                   in_ready,
    output maki_pkg::cmd_t         cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EX_A = 3'd1;
    localparam logic [2:0] S_EX_F = 3'd2;
    localparam logic [2:0] S_EX_H = 3'd3;
    localparam logic [2:0] S_EX_L = 3'd4;
    localparam logic [2:0] S_EX_W = 3'd5;
    localparam logic [2:0] S_FE_R = 3'd6;
    localparam logic [2:0] S_FE_C = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_xfer) begin
                    case (in_mode) inside
                        maki_pkg::MODE_FLAG_A, maki_pkg::MODE_FLAG_B,
                        maki_pkg::MODE_PIXEL: cmd.load = 1'b1;
                        maki_pkg::MODE_START: begin
                            cmd.start  = 1'b1;
                            state_next = S_EX_A;
                        end
                        maki_pkg::MODE_FETCH: begin
                            if (st.frame_active) begin
                                cmd.fe_rd  = 1'b1;
                                state_next = S_FE_C;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_EX_A: begin
                cmd.ex_rd_a = 1'b1;
                state_next  = S_EX_F;
            end
            S_EX_F: begin
                if (st.fa_bit) begin
                    cmd.ex_rd_b = 1'b1;
                    state_next  = S_EX_H;
                end else begin
                    cmd.ex_clr = 1'b1;
                    state_next = S_EX_W;
                end
            end
            S_EX_H: begin
                cmd.ex_cap_hi = 1'b1;
                cmd.ex_rd_b   = 1'b1;
                state_next    = S_EX_L;
            end
            S_EX_L: begin
                cmd.ex_cap_lo = 1'b1;
                state_next    = S_EX_W;
            end
            S_EX_W: begin
                cmd.ex_wr = 1'b1;
                if (st.nib_last) begin
                    state_next = st.blk_last ? S_IDLE : S_EX_A;
                end
            end
            S_FE_R: begin
                cmd.fe_rd  = 1'b1;
                state_next = S_FE_C;
            end
            S_FE_C: begin
                if (st.out_free) begin
                    cmd.fe_commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* src/maki_datapath.sv */
`default_nettype none
module maki_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire maki_pkg::cmd_t cmd,
    input  wire logic [2:0]     in_mode,
    input  wire logic [7:0]     in_byte,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_idx,
    input  wire logic [9:0]     cfg_val,
    input  wire logic           out_ready,
    output maki_pkg::status_t   st,
    output logic                out_valid,
    output logic [3:0]          out_left,
    output logic [3:0]          out_right,
    output logic                out_last,
    output logic                out_bad
);
    // stores
    logic [7:0] fa_mem [maki_pkg::FLAG_A_BYTES];
    logic [7:0] fb_mem [maki_pkg::FLAG_B_BYTES];
    logic [7:0] px_mem [maki_pkg::PIXEL_BYTES];
    logic [3:0] vs_mem [maki_pkg::VS_NIBBLES];
    logic [7:0] rr_mem [maki_pkg::RECENT_DEPTH];

    logic [9:0]  width_reg;
    logic [8:0]  height_reg;
    logic        varb_reg;

    logic [9:0]  fa_cnt_reg;
    logic [14:0] fb_cnt_reg;
    logic [17:0] px_cnt_reg;

    logic [5:0]  w16_reg;
    logic [6:0]  h4_reg;
    logic        gap4_reg;
    logic        err_reg;
    logic        active_reg;

    // expansion
    logic [12:0] k_reg;
    logic [6:0]  blk_reg;
    logic [6:0]  by_reg;
    logic [14:0] rb_reg;
    logic [14:0] waddr_reg;
    logic [1:0]  r_reg;
    logic [14:0] fb_idx_reg;
    logic        fa_ok_reg;
    logic [7:0]  fa_rd_reg;
    logic        fb_ok_reg;
    logic [7:0]  fb_rd_reg;
    logic [3:0]  nib_reg [4];

    // fetch
    logic [8:0]  xp_reg;
    logic [8:0]  y_reg;
    logic [14:0] vrow_reg;
    logic [17:0] ptr_reg;
    logic [3:0]  vs_rd_reg;
    logic [7:0]  px_rd_reg;
    logic [7:0]  rr_rd_reg;

    logic        out_valid_reg;
    logic [3:0]  left_reg, right_reg;
    logic        last_reg, bad_reg;

    logic [6:0]  bw;
    logic [8:0]  ppr;
    logic [5:0]  w16_next;
    logic [6:0]  h4_next;
    logic [7:0]  fb_byte;
    logic [1:0]  slot_cur, slot_prev;
    logic [10:0] rr_raddr, rr_waddr;
    logic        have_prev, pix_bit, px_ok, row_end, frame_end, err_next;
    logic [3:0]  l_val, r_val;

    assign bw  = {w16_reg, 1'b0};
    assign ppr = {w16_reg, 3'b000};

    always_comb begin
        w16_next = width_reg[9:4];
        if (w16_next > maki_pkg::W16_MAX) w16_next = maki_pkg::W16_MAX;
        if (w16_next == 6'd0) w16_next = 6'd1;
        h4_next = height_reg[8:2];
        if (h4_next > maki_pkg::H4_MAX) h4_next = maki_pkg::H4_MAX;
        if (h4_next == 7'd0) h4_next = 7'd1;
    end

    assign fb_byte = fb_ok_reg ? fb_rd_reg : 8'h00;

    assign slot_cur  = y_reg[1:0];
    assign slot_prev = gap4_reg ? y_reg[1:0] : y_reg[1:0] + 2'd2;
    assign have_prev = gap4_reg ? (y_reg >= 9'd4) : (y_reg >= 9'd2);
    assign rr_raddr  = {1'b0, slot_prev, 8'h00} + {3'b000, slot_prev, 6'h00} + {2'b00, xp_reg};
    assign rr_waddr  = {1'b0, slot_cur, 8'h00} + {3'b000, slot_cur, 6'h00} + {2'b00, xp_reg};

    assign pix_bit   = vs_rd_reg[~xp_reg[1:0]];
    assign px_ok     = ptr_reg < px_cnt_reg;
    assign row_end   = xp_reg == ppr - 9'd1;
    assign frame_end = row_end && (y_reg == {h4_reg, 2'b00} - 9'd1);
    assign err_next  = err_reg | (pix_bit & ~px_ok);

    always_comb begin
        l_val = 4'h0;
        r_val = 4'h0;
        if (pix_bit && px_ok) begin
            l_val = px_rd_reg[7:4];
            r_val = px_rd_reg[3:0];
        end
        if (have_prev) begin
            l_val = l_val ^ rr_rd_reg[7:4];
            r_val = r_val ^ rr_rd_reg[3:0];
        end
    end

    assign st.frame_active = active_reg;
    assign st.fa_bit       = fa_ok_reg & fa_rd_reg[~k_reg[2:0]];
    assign st.nib_last     = r_reg == 2'd3;
    assign st.blk_last     = (blk_reg == bw - 7'd1) && (by_reg == h4_reg - 7'd1);
    assign st.out_free     = !out_valid_reg || out_ready;

    // memory ports
    always_ff @(posedge aclk) begin
        if (cmd.load && in_mode == maki_pkg::MODE_FLAG_A
                && fa_cnt_reg < 10'(maki_pkg::FLAG_A_BYTES)) begin
            fa_mem[fa_cnt_reg] <= in_byte;
        end
        if (cmd.ex_rd_a) begin
            fa_rd_reg <= fa_mem[k_reg[12:3]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && in_mode == maki_pkg::MODE_FLAG_B
                && fb_cnt_reg < 15'(maki_pkg::FLAG_B_BYTES)) begin
            fb_mem[fb_cnt_reg[13:0]] <= in_byte;
        end
        if (cmd.ex_rd_b) begin
            fb_rd_reg <= fb_mem[fb_idx_reg[13:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && in_mode == maki_pkg::MODE_PIXEL
                && px_cnt_reg < 18'(maki_pkg::PIXEL_BYTES)) begin
            px_mem[px_cnt_reg[16:0]] <= in_byte;
        end
        if (cmd.fe_rd) begin
            px_rd_reg <= px_mem[ptr_reg[16:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ex_wr) begin
            vs_mem[waddr_reg] <= nib_reg[r_reg];
        end
        if (cmd.fe_rd) begin
            vs_rd_reg <= vs_mem[vrow_reg + {8'h00, xp_reg[8:2]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fe_commit) begin
            rr_mem[rr_waddr] <= {l_val, r_val};
        end
        if (cmd.fe_rd) begin
            rr_rd_reg <= rr_mem[rr_raddr];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.ex_rd_a) begin
            fa_ok_reg <= k_reg[12:3] < fa_cnt_reg;
            waddr_reg <= rb_reg + {8'h00, blk_reg};
            r_reg     <= 2'd0;
        end
        if (cmd.ex_rd_b) begin
            fb_ok_reg <= fb_idx_reg < fb_cnt_reg;
        end
        if (cmd.ex_clr) begin
            for (int i = 0; i < 4; i++) nib_reg[i] <= 4'h0;
        end
        if (cmd.ex_cap_hi) begin
            nib_reg[0] <= fb_byte[7:4];
            nib_reg[1] <= fb_byte[3:0];
        end
        if (cmd.ex_cap_lo) begin
            nib_reg[2] <= fb_byte[7:4];
            nib_reg[3] <= fb_byte[3:0];
        end
        if (cmd.ex_wr) begin
            r_reg     <= r_reg + 2'd1;
            waddr_reg <= waddr_reg + {8'h00, bw};
        end
        if (cmd.fe_commit) begin
            left_reg  <= l_val;
            right_reg <= r_val;
            last_reg  <= frame_end;
            bad_reg   <= err_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= 10'(maki_pkg::MAX_WIDTH);
            height_reg    <= 9'(maki_pkg::MAX_HEIGHT);
            varb_reg      <= 1'b0;
            fa_cnt_reg    <= '0;
            fb_cnt_reg    <= '0;
            px_cnt_reg    <= '0;
            w16_reg       <= 6'd1;
            h4_reg        <= 7'd1;
            gap4_reg      <= 1'b0;
            err_reg       <= 1'b0;
            active_reg    <= 1'b0;
            k_reg         <= '0;
            blk_reg       <= '0;
            by_reg        <= '0;
            rb_reg        <= '0;
            fb_idx_reg    <= '0;
            xp_reg        <= '0;
            y_reg         <= '0;
            vrow_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    maki_pkg::REG_WIDTH:   width_reg  <= cfg_val;
                    maki_pkg::REG_HEIGHT:  height_reg <= cfg_val[8:0];
                    maki_pkg::REG_VARIANT: varb_reg   <= cfg_val[0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                case (in_mode)
                    maki_pkg::MODE_FLAG_A:
                        if (fa_cnt_reg < 10'(maki_pkg::FLAG_A_BYTES))
                            fa_cnt_reg <= fa_cnt_reg + 10'd1;
                    maki_pkg::MODE_FLAG_B:
                        if (fb_cnt_reg < 15'(maki_pkg::FLAG_B_BYTES))
                            fb_cnt_reg <= fb_cnt_reg + 15'd1;
                    maki_pkg::MODE_PIXEL:
                        if (px_cnt_reg < 18'(maki_pkg::PIXEL_BYTES))
                            px_cnt_reg <= px_cnt_reg + 18'd1;
                    default: ;
                endcase
            end
            if (cmd.start) begin
                w16_reg    <= w16_next;
                h4_reg     <= h4_next;
                gap4_reg   <= varb_reg;
                err_reg    <= 1'b0;
                active_reg <= 1'b0;
                k_reg      <= '0;
                blk_reg    <= '0;
                by_reg     <= '0;
                rb_reg     <= '0;
                fb_idx_reg <= '0;
                xp_reg     <= '0;
                y_reg      <= '0;
                vrow_reg   <= '0;
                ptr_reg    <= '0;
            end
            if (cmd.ex_rd_b) begin
                if (fb_idx_reg < fb_cnt_reg) fb_idx_reg <= fb_idx_reg + 15'd1;
                else                         err_reg    <= 1'b1;
            end
            if (cmd.ex_wr && r_reg == 2'd3) begin
                k_reg <= k_reg + 13'd1;
                if (blk_reg == bw - 7'd1) begin
                    blk_reg <= '0;
                    by_reg  <= by_reg + 7'd1;
                    rb_reg  <= rb_reg + {6'h00, bw, 2'b00};
                    if (by_reg == h4_reg - 7'd1) active_reg <= 1'b1;
                end else begin
                    blk_reg <= blk_reg + 7'd1;
                end
            end
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (cmd.fe_commit) begin
                out_valid_reg <= 1'b1;
                err_reg       <= err_next;
                if (pix_bit && px_ok) ptr_reg <= ptr_reg + 18'd1;
                if (row_end) begin
                    xp_reg   <= '0;
                    y_reg    <= y_reg + 9'd1;
                    vrow_reg <= vrow_reg + {8'h00, bw};
                end else begin
                    xp_reg <= xp_reg + 9'd1;
                end
                if (frame_end) active_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = left_reg;
    assign out_right = right_reg;
    assign out_last  = last_reg;
    assign out_bad   = bad_reg;
endmodule
`default_nettype wire

/* src/maki_image_decoder.sv */
`default_nettype none
// MAKI 16-colour picture decoder. Stream in flag-A, flag-B and pixel bytes
// (mode 0/1/2, one transfer a cycle while idle), send a start (mode 3), then one
// fetch (mode 4) per pixel pair; each fetch in an active frame yields one result
// transfer in raster order, tlast on the final pair, tuser the sticky
// bad-data flag. A fetch issues the registered reads of the screen, pixel
// and recent-row memories in its accepting cycle, then combines and writes
// back once the result register is free. After its accepting cycle a start
// walks every 4x4 flag block of the picture: it reads a flag-A bit, reads
// two flag-B bytes when that bit is set or else clears the nibbles, and
// makes four screen writes per block; no item is taken meanwhile. Geometry
// and variant are latched at start; configure only while idle. Loaded
// counts are cleared only by reset.
module maki_image_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // mode[2:0], data_byte[10:3], zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [9:0]  cfg_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // left_pixel[3:0], right_pixel[7:4]
    output logic             m_tlast,   // last_pair
    output logic             m_tuser    // bad_data
);
    maki_pkg::cmd_t    cmd;
    maki_pkg::status_t st;
    logic [3:0] left, right;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    maki_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_xfer  (s_tvalid && s_tready),
        .in_mode  (s_tdata[2:0]),
        .st       (st),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    maki_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_mode   (s_tdata[2:0]),
        .in_byte   (s_tdata[10:3]),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_val   (cfg_data),
        .out_ready (m_tready),
        .st        (st),
        .out_valid (m_tvalid),
        .out_left  (left),
        .out_right (right),
        .out_last  (m_tlast),
        .out_bad   (m_tuser)
    );

    assign m_tdata = {right, left};
endmodule
`default_nettype wire

/* src/maki_checker.sv */
`default_nettype none
module maki_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

    a_last_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result straight after last pair");

    a_no_spont: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(!(s_tvalid && s_tready)) && $past(!s_tready, 2) == 1'b0
            && $past(s_tready) |=> !m_tvalid || $past(m_tvalid))
        else $error("result without a fetch");
endmodule

bind maki_image_decoder maki_checker u_maki_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
